// File: src/cvgs_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// cvgs_pkg
// Shared constants and types for the cluster visit goal selector.
// ============================================================================
package cvgs_pkg;

    localparam int MAX_BOXES = 64;
    localparam int BOX_AW    = $clog2(MAX_BOXES);
    localparam int CNT_W     = $clog2(MAX_BOXES + 1);

    localparam int COORD_W = 24;
    localparam int SIZE_W  = 20;
    localparam int HALF_W  = 19;
    localparam int CFG_W   = 16;

    // Item kinds.
    localparam logic [1:0] KIND_ODOM = 2'd0;
    localparam logic [1:0] KIND_BOX  = 2'd1;
    localparam logic [1:0] KIND_END  = 2'd2;

    // Register indexes.
    localparam logic [1:0] REG_VISIT_OFFSET = 2'd0;
    localparam logic [1:0] REG_REACH_RADIUS = 2'd1;
    localparam logic [1:0] REG_DEDUP_RADIUS = 2'd2;
    localparam logic [1:0] REG_GOAL_RADIUS  = 2'd3;

    // One row of the box table.
    typedef struct packed {
        logic                       visited;
        logic [HALF_W-1:0]          half_h;
        logic [HALF_W-1:0]          half_w;
        logic signed [COORD_W-1:0]  cy;
        logic signed [COORD_W-1:0]  cx;
    } box_row_t;

    localparam int ROW_W = $bits(box_row_t);

endpackage

// File: src/cluster_visit_goal_selector.sv
`timescale 1ns / 1ps
// ============================================================================
// cluster_visit_goal_selector
// Box table with deduplication and nearest visit point goal selection.
// ============================================================================
// Usage:
// Requests arrive on the input channel (in_valid / in_ready) with a kind and
// position fields. An odometry request (kind 0) records the robot position.
// A box request (kind 1) scans the stored table for a center that lies
// within the dedup radius and appends the box only if none does and the
// table has room. An end request (kind 2) scans the table once, evaluates
// the four visit points of every box, keeps the nearest unvisited point and
// marks boxes the robot has reached. Only end requests produce a result on
// the output channel (out_valid / out_ready); kind 3 is ignored.
// A scan walks the stored boxes (at most 64) one at a time, bounded by the
// single table RAM read port and the shared squared distance unit. Each box
// is read in SETUP, each point goes through PT, MUL and CMP in turn, and an
// end request writes each box back in WB. One request is worked on at a
// time; in_ready is high only while the sequencer is idle.
// The result sits in an output register, so a new request is taken while a
// result still waits. If the receiver stalls and a second end request
// finishes, the sequencer holds until the first result is taken.
// Reset clears the box count, the robot position, the overflow flag and the
// registers to their defaults; the table itself needs no clearing pass.
// ============================================================================
module cluster_visit_goal_selector (
    input  logic                                clk,
    input  logic                                rst_n,
    // Configuration port.
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [3:0]                          paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready,
    // Input channel.
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [1:0]                          kind,
    input  logic signed [cvgs_pkg::COORD_W-1:0] pos_x,
    input  logic signed [cvgs_pkg::COORD_W-1:0] pos_y,
    input  logic [cvgs_pkg::SIZE_W-1:0]         size_w,
    input  logic [cvgs_pkg::SIZE_W-1:0]         size_h,
    // Output channel.
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                goal_valid,
    output logic signed [cvgs_pkg::COORD_W-1:0] goal_x,
    output logic signed [cvgs_pkg::COORD_W-1:0] goal_y,
    output logic [cvgs_pkg::CNT_W-1:0]          box_count,
    output logic                                table_overflow
);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_SETUP = 8'b0000_0010,
        S_FETCH = 8'b0000_0100,
        S_PT    = 8'b0000_1000,
        S_MUL   = 8'b0001_0000,
        S_CMP   = 8'b0010_0000,
        S_WB    = 8'b0100_0000,
        S_FIN   = 8'b1000_0000
    } state_t;

    localparam int EXT_W = cvgs_pkg::COORD_W + 2;   // room for center +/- half size plus offset
    localparam int DIF_W = cvgs_pkg::COORD_W + 1;
    localparam int SQ_W  = 2 * cvgs_pkg::COORD_W + 1;
    localparam int D2_W  = SQ_W + 1;

    // Saturate a widened coordinate to 24-bit signed.
    function automatic logic signed [cvgs_pkg::COORD_W-1:0] sat24(
        input logic signed [EXT_W-1:0] v
    );
        logic signed [EXT_W-1:0] hi;
        logic signed [EXT_W-1:0] lo;
        hi = EXT_W'(signed'({1'b0, {(cvgs_pkg::COORD_W-1){1'b1}}}));
        lo = -hi - EXT_W'(1);
        if (v > hi)
        begin
            sat24 = hi[cvgs_pkg::COORD_W-1:0];
        end
        else if (v < lo)
        begin
            sat24 = lo[cvgs_pkg::COORD_W-1:0];
        end
        else
        begin
            sat24 = v[cvgs_pkg::COORD_W-1:0];
        end
    endfunction

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    logic [cvgs_pkg::CFG_W-1:0] visit_offset_reg;
    logic [cvgs_pkg::CFG_W-1:0] reach_radius_reg;
    logic [cvgs_pkg::CFG_W-1:0] dedup_radius_reg;
    logic [cvgs_pkg::CFG_W-1:0] goal_radius_reg;
    logic                       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            visit_offset_reg <= 16'd750;
            reach_radius_reg <= 16'd500;
            dedup_radius_reg <= 16'd300;
            goal_radius_reg  <= 16'd300;
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                cvgs_pkg::REG_VISIT_OFFSET: visit_offset_reg <= pwdata[15:0];
                cvgs_pkg::REG_REACH_RADIUS: reach_radius_reg <= pwdata[15:0];
                cvgs_pkg::REG_DEDUP_RADIUS: dedup_radius_reg <= pwdata[15:0];
                cvgs_pkg::REG_GOAL_RADIUS:  goal_radius_reg  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            cvgs_pkg::REG_VISIT_OFFSET: prdata = {16'd0, visit_offset_reg};
            cvgs_pkg::REG_REACH_RADIUS: prdata = {16'd0, reach_radius_reg};
            cvgs_pkg::REG_DEDUP_RADIUS: prdata = {16'd0, dedup_radius_reg};
            cvgs_pkg::REG_GOAL_RADIUS:  prdata = {16'd0, goal_radius_reg};
            default:                    prdata = 32'd0;
        endcase
    end

    // ------------------------------------------------------------------
    // Control and datapath registers.
    // ------------------------------------------------------------------
    state_t                             state_reg, state_next;
    logic [1:0]                         kind_reg;
    logic signed [cvgs_pkg::COORD_W-1:0] item_x_reg, item_y_reg;
    logic [cvgs_pkg::HALF_W-1:0]        item_hw_reg, item_hh_reg;
    logic signed [cvgs_pkg::COORD_W-1:0] robot_x_reg, robot_y_reg;
    logic [cvgs_pkg::CNT_W-1:0]         count_reg;
    logic                               overflow_reg;
    logic [cvgs_pkg::CNT_W-1:0]         idx_reg;
    logic [1:0]                         pt_reg;
    logic [31:0]                        thr_sq_reg;
    logic [31:0]                        goal_sq_reg;
    logic signed [DIF_W-1:0]            dx_reg, dy_reg;
    logic signed [cvgs_pkg::COORD_W-1:0] px_reg, py_reg;
    logic [SQ_W-1:0]                    sqx_reg, sqy_reg;
    logic signed [cvgs_pkg::COORD_W-1:0] cand_x_reg, cand_y_reg;
    logic                               found_reg;
    logic [D2_W-1:0]                    best_reg;
    logic signed [cvgs_pkg::COORD_W-1:0] best_x_reg, best_y_reg;
    logic                               hit_reg;

    logic                               out_valid_reg;
    logic                               goal_valid_reg;
    logic signed [cvgs_pkg::COORD_W-1:0] goal_x_reg, goal_y_reg;
    logic [cvgs_pkg::CNT_W-1:0]         box_count_reg;
    logic                               table_overflow_reg;

    // ------------------------------------------------------------------
    // Table RAM.
    // ------------------------------------------------------------------
    logic                        ram_we;
    logic [cvgs_pkg::BOX_AW-1:0] ram_waddr;
    cvgs_pkg::box_row_t          ram_wdata;
    logic                        ram_re;
    cvgs_pkg::box_row_t          row;
    logic [cvgs_pkg::ROW_W-1:0]  ram_rdata;

    cvgs_ram #(
        .WIDTH (cvgs_pkg::ROW_W),
        .DEPTH (cvgs_pkg::MAX_BOXES)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (idx_reg[cvgs_pkg::BOX_AW-1:0]),
        .rdata (ram_rdata)
    );

    assign row = cvgs_pkg::box_row_t'(ram_rdata);

    // ------------------------------------------------------------------
    // Point generation and distance datapath.
    // ------------------------------------------------------------------
    logic [cvgs_pkg::SIZE_W-1:0]        hh_d, hw_d;
    logic signed [EXT_W-1:0]            cx_ext, cy_ext;
    logic signed [cvgs_pkg::COORD_W-1:0] pnt_x, pnt_y;
    logic signed [cvgs_pkg::COORD_W-1:0] ref_x, ref_y;
    logic signed [cvgs_pkg::COORD_W-1:0] tgt_x, tgt_y;
    logic signed [2*DIF_W-1:0]          prod_x, prod_y;
    logic [D2_W-1:0]                    d2;
    logic                               in_fire;
    logic                               is_box;
    logic                               out_free;
    logic                               better;

    assign hh_d   = cvgs_pkg::SIZE_W'(row.half_h) + cvgs_pkg::SIZE_W'(visit_offset_reg);
    assign hw_d   = cvgs_pkg::SIZE_W'(row.half_w) + cvgs_pkg::SIZE_W'(visit_offset_reg);
    assign cx_ext = EXT_W'(row.cx);
    assign cy_ext = EXT_W'(row.cy);

    // Visit points in the order bottom, top, left, right.
    always_comb
    begin
        pnt_x = row.cx;
        pnt_y = row.cy;
        case (pt_reg)
            2'd0: pnt_y = sat24(cy_ext - EXT_W'(signed'({1'b0, hh_d})));
            2'd1: pnt_y = sat24(cy_ext + EXT_W'(signed'({1'b0, hh_d})));
            2'd2: pnt_x = sat24(cx_ext - EXT_W'(signed'({1'b0, hw_d})));
            default: pnt_x = sat24(cx_ext + EXT_W'(signed'({1'b0, hw_d})));
        endcase
    end

    // A box request measures against stored centers, an end request
    // measures the robot against each visit point.
    assign is_box = (kind_reg == cvgs_pkg::KIND_BOX);
    assign ref_x  = is_box ? item_x_reg : robot_x_reg;
    assign ref_y  = is_box ? item_y_reg : robot_y_reg;
    assign tgt_x  = is_box ? row.cx : pnt_x;
    assign tgt_y  = is_box ? row.cy : pnt_y;

    assign prod_x = dx_reg * dx_reg;
    assign prod_y = dy_reg * dy_reg;
    assign d2     = D2_W'(sqx_reg) + D2_W'(sqy_reg);
    assign better = !found_reg || (d2 < best_reg);

    assign in_ready = (state_reg == S_IDLE);
    assign in_fire  = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    // ------------------------------------------------------------------
    // Sequencer.
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        ram_re     = 1'b0;
        ram_we     = 1'b0;
        ram_waddr  = idx_reg[cvgs_pkg::BOX_AW-1:0];
        ram_wdata  = row;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire && (kind == cvgs_pkg::KIND_BOX || kind == cvgs_pkg::KIND_END))
                begin
                    state_next = S_SETUP;
                end
            end
            S_SETUP:
            begin
                if (idx_reg < count_reg)
                begin
                    ram_re     = 1'b1;
                    state_next = S_PT;
                end
                else if (is_box)
                begin
                    // Scan found no duplicate: append if there is room.
                    if (count_reg < cvgs_pkg::CNT_W'(cvgs_pkg::MAX_BOXES))
                    begin
                        ram_we            = 1'b1;
                        ram_waddr         = count_reg[cvgs_pkg::BOX_AW-1:0];
                        ram_wdata.visited = 1'b0;
                        ram_wdata.half_h  = item_hh_reg;
                        ram_wdata.half_w  = item_hw_reg;
                        ram_wdata.cy      = item_y_reg;
                        ram_wdata.cx      = item_x_reg;
                    end
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_PT:
            begin
                state_next = S_MUL;
            end
            S_MUL:
            begin
                state_next = S_CMP;
            end
            S_CMP:
            begin
                if (is_box)
                begin
                    state_next = (d2 < D2_W'(thr_sq_reg)) ? S_IDLE : S_SETUP;
                end
                else if (pt_reg == 2'd3)
                begin
                    state_next = S_WB;
                end
                else
                begin
                    state_next = S_PT;
                end
            end
            S_WB:
            begin
                ram_we            = 1'b1;
                ram_wdata.visited = row.visited || hit_reg;
                state_next        = S_SETUP;
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            robot_x_reg   <= '0;
            robot_y_reg   <= '0;
            count_reg     <= '0;
            overflow_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            kind_reg      <= cvgs_pkg::KIND_ODOM;
            idx_reg       <= '0;
            pt_reg        <= '0;
            found_reg     <= 1'b0;
            hit_reg       <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            // A finished end request loads the output register; otherwise a
            // taken result empties it.
            if (state_reg == S_FIN && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_fire)
                    begin
                        kind_reg  <= kind;
                        idx_reg   <= '0;
                        found_reg <= 1'b0;
                        hit_reg   <= 1'b0;
                        if (kind == cvgs_pkg::KIND_ODOM)
                        begin
                            robot_x_reg <= pos_x;
                            robot_y_reg <= pos_y;
                        end
                    end
                end
                S_SETUP:
                begin
                    pt_reg  <= '0;
                    hit_reg <= 1'b0;
                    if (!(idx_reg < count_reg) && is_box)
                    begin
                        if (count_reg < cvgs_pkg::CNT_W'(cvgs_pkg::MAX_BOXES))
                        begin
                            count_reg <= count_reg + 1'b1;
                        end
                        else
                        begin
                            overflow_reg <= 1'b1;
                        end
                    end
                end
                S_CMP:
                begin
                    if (is_box)
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                    else
                    begin
                        pt_reg <= pt_reg + 2'd1;
                        if (!row.visited && better)
                        begin
                            found_reg <= 1'b1;
                        end
                        if (d2 < D2_W'(thr_sq_reg))
                        begin
                            hit_reg <= 1'b1;
                        end
                    end
                end
                S_WB:
                begin
                    idx_reg <= idx_reg + 1'b1;
                end
                S_FIN:
                begin
                    if (out_free)
                    begin
                        overflow_reg <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    item_x_reg  <= pos_x;
                    item_y_reg  <= pos_y;
                    item_hw_reg <= size_w[cvgs_pkg::SIZE_W-1:1];
                    item_hh_reg <= size_h[cvgs_pkg::SIZE_W-1:1];
                    thr_sq_reg  <= (kind == cvgs_pkg::KIND_BOX)
                                 ? 32'(dedup_radius_reg) * 32'(dedup_radius_reg)
                                 : 32'(reach_radius_reg) * 32'(reach_radius_reg);
                    goal_sq_reg <= 32'(goal_radius_reg) * 32'(goal_radius_reg);
                end
            end
            S_PT:
            begin
                dx_reg <= DIF_W'(ref_x) - DIF_W'(tgt_x);
                dy_reg <= DIF_W'(ref_y) - DIF_W'(tgt_y);
                px_reg <= tgt_x;
                py_reg <= tgt_y;
            end
            S_MUL:
            begin
                sqx_reg    <= prod_x[SQ_W-1:0];
                sqy_reg    <= prod_y[SQ_W-1:0];
                cand_x_reg <= px_reg;
                cand_y_reg <= py_reg;
            end
            S_CMP:
            begin
                if (!is_box && !row.visited && better)
                begin
                    best_reg   <= d2;
                    best_x_reg <= cand_x_reg;
                    best_y_reg <= cand_y_reg;
                end
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    goal_valid_reg     <= found_reg && (best_reg > D2_W'(goal_sq_reg));
                    goal_x_reg         <= (found_reg && (best_reg > D2_W'(goal_sq_reg)))
                                        ? best_x_reg : '0;
                    goal_y_reg         <= (found_reg && (best_reg > D2_W'(goal_sq_reg)))
                                        ? best_y_reg : '0;
                    box_count_reg      <= count_reg;
                    table_overflow_reg <= overflow_reg;
                end
            end
            default: ;
        endcase
    end

    assign out_valid      = out_valid_reg;
    assign goal_valid     = goal_valid_reg;
    assign goal_x         = goal_x_reg;
    assign goal_y         = goal_y_reg;
    assign box_count      = box_count_reg;
    assign table_overflow = table_overflow_reg;

endmodule

// File: src/cvgs_ram.sv
`timescale 1ns / 1ps
// ============================================================================
// cvgs_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ============================================================================
module cvgs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: src/cvgs_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// cvgs_checker
// Port-level assertions for the cluster visit goal selector.
// ============================================================================
module cvgs_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_ready,
    input  logic                                out_valid,
    input  logic                                out_ready,
    input  logic                                goal_valid,
    input  logic signed [cvgs_pkg::COORD_W-1:0] goal_x,
    input  logic signed [cvgs_pkg::COORD_W-1:0] goal_y,
    input  logic [cvgs_pkg::CNT_W-1:0]          box_count
);

    // A stalled result stays valid and keeps its goal coordinates.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(goal_x) && $stable(goal_y))
        else $error("stalled result changed");

    // Without a goal the coordinates read zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !goal_valid |-> goal_x == '0 && goal_y == '0)
        else $error("goal coordinates not zero without goal");

    // The table never reports more boxes than it holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> box_count <= cvgs_pkg::CNT_W'(cvgs_pkg::MAX_BOXES))
        else $error("box count beyond table depth");

    // A new result appears only when the sequencer has just been busy.
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid ##1 out_valid |-> !in_ready || !$past(in_ready))
        else $error("result without a request in flight");

endmodule

bind cluster_visit_goal_selector cvgs_checker u_cvgs_checker (.*);

// File: verif/tb.sv
`timescale 1ns / 1ps
// ============================================================================
// tb
// Self-checking bench for the cluster visit goal selector.
// ============================================================================
// Odometry, box and end requests are sent on the input channel. A predictor
// inside the bench keeps its own copy of the box table, the robot position
// and the four registers. From these it works out the goal result of every
// accepted end request and queues it. A monitor compares each result taken
// from the output channel, field by field, with the oldest queued goal.
// Both channels may idle in random bursts. One phase holds the receiver
// off for a long stretch so that the block backs up and stalls its input.
// ============================================================================
module tb;

    typedef struct {
        logic                                gv;
        logic signed [cvgs_pkg::COORD_W-1:0] gx;
        logic signed [cvgs_pkg::COORD_W-1:0] gy;
        logic [cvgs_pkg::CNT_W-1:0]          cnt;
        logic                                ovf;
    } goal_t;

    localparam longint COORD_MAX = 64'sd8388607;
    localparam longint COORD_MIN = -64'sd8388608;
    localparam int     LIMIT     = 20_000_000;
    // Slowest request: an end scan over a full table, plus some slack.
    localparam int     SETTLE    = 1000;

    logic                                clk;
    logic                                rst_n;
    logic                                psel, penable, pwrite, pready;
    logic [3:0]                          paddr;
    logic [31:0]                         pwdata, prdata;
    logic                                in_valid, in_ready;
    logic [1:0]                          kind;
    logic signed [cvgs_pkg::COORD_W-1:0] pos_x, pos_y;
    logic [cvgs_pkg::SIZE_W-1:0]         size_w, size_h;
    logic                                out_valid, out_ready;
    logic                                goal_valid;
    logic signed [cvgs_pkg::COORD_W-1:0] goal_x, goal_y;
    logic [cvgs_pkg::CNT_W-1:0]          box_count;
    logic                                table_overflow;

    cluster_visit_goal_selector dut (.*);

    // Predictor state: a private copy of everything the block remembers.
    longint     robot_x, robot_y;
    longint     tbl_cx [cvgs_pkg::MAX_BOXES];
    longint     tbl_cy [cvgs_pkg::MAX_BOXES];
    longint     tbl_hw [cvgs_pkg::MAX_BOXES];
    longint     tbl_hh [cvgs_pkg::MAX_BOXES];
    bit         tbl_seen [cvgs_pkg::MAX_BOXES];
    int         n_boxes;
    bit         dropped_box;
    longint     offset_mm, reach_mm, dedup_mm, goal_mm;

    goal_t      goal_q[$];
    int         errors;
    bit         idle_en;
    int         stall_left;
    longint     cycles;

    // ------------------------------------------------------------------
    // Clock, reset and the cycle limit.
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("tb NOT OK");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Predictor.
    // ------------------------------------------------------------------
    function automatic longint clamp_coord(input longint v);
        if (v > COORD_MAX) return COORD_MAX;
        if (v < COORD_MIN) return COORD_MIN;
        return v;
    endfunction

    // Side points in order bottom, top, left, right, always with the
    // current offset, so an offset change moves points of old boxes too.
    function automatic void side_point(input int b, input int k,
                                       output longint px, output longint py);
        px = tbl_cx[b];
        py = tbl_cy[b];
        case (k)
            0: py = clamp_coord(tbl_cy[b] - tbl_hh[b] - offset_mm);
            1: py = clamp_coord(tbl_cy[b] + tbl_hh[b] + offset_mm);
            2: px = clamp_coord(tbl_cx[b] - tbl_hw[b] - offset_mm);
            default: px = clamp_coord(tbl_cx[b] + tbl_hw[b] + offset_mm);
        endcase
    endfunction

    function automatic longint dist_sq(input longint ax, input longint ay,
                                       input longint bx, input longint by);
        return (ax - bx) * (ax - bx) + (ay - by) * (ay - by);
    endfunction

    // Apply one accepted request to the predictor and queue the goal that
    // an end request must produce.
    function automatic void track_request(input logic [1:0] k,
                                          input longint x, input longint y,
                                          input longint w, input longint h);
        longint px, py, d2, best;
        bit     found;
        goal_t  g;
        if (k == cvgs_pkg::KIND_ODOM)
        begin
            robot_x = x;
            robot_y = y;
        end
        else if (k == cvgs_pkg::KIND_BOX)
        begin
            for (int i = 0; i < n_boxes; i++)
                if (dist_sq(x, y, tbl_cx[i], tbl_cy[i]) < dedup_mm * dedup_mm)
                    return;
            if (n_boxes >= cvgs_pkg::MAX_BOXES)
            begin
                dropped_box = 1'b1;
                return;
            end
            tbl_cx[n_boxes]   = x;
            tbl_cy[n_boxes]   = y;
            tbl_hw[n_boxes]   = w >> 1;
            tbl_hh[n_boxes]   = h >> 1;
            tbl_seen[n_boxes] = 1'b0;
            n_boxes++;
        end
        else if (k == cvgs_pkg::KIND_END)
        begin
            found = 1'b0;
            best  = 0;
            g.gx  = '0;
            g.gy  = '0;
            for (int b = 0; b < n_boxes; b++)
            begin
                if (tbl_seen[b]) continue;
                for (int s = 0; s < 4; s++)
                begin
                    side_point(b, s, px, py);
                    d2 = dist_sq(robot_x, robot_y, px, py);
                    // Strict compare: the first point wins a tie.
                    if (!found || d2 < best)
                    begin
                        found = 1'b1;
                        best  = d2;
                        g.gx  = px[cvgs_pkg::COORD_W-1:0];
                        g.gy  = py[cvgs_pkg::COORD_W-1:0];
                    end
                end
            end
            g.gv = found && (best > goal_mm * goal_mm);
            if (!g.gv)
            begin
                g.gx = '0;
                g.gy = '0;
            end
            // Reach marking covers already visited boxes as well.
            for (int b = 0; b < n_boxes; b++)
                for (int s = 0; s < 4; s++)
                begin
                    side_point(b, s, px, py);
                    if (dist_sq(robot_x, robot_y, px, py) < reach_mm * reach_mm)
                    begin
                        tbl_seen[b] = 1'b1;
                        break;
                    end
                end
            g.cnt = n_boxes[cvgs_pkg::CNT_W-1:0];
            g.ovf = dropped_box;
            dropped_box = 1'b0;
            goal_q.insert(goal_q.size(), g);
        end
        // The unused kind leaves everything alone.
    endfunction

    // ------------------------------------------------------------------
    // Result monitor: runs at every rising edge and compares against the
    // oldest queued goal.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        goal_t g;
        if (rst_n && out_valid && out_ready)
        begin
            if (goal_q.size() == 0)
            begin
                $error("result with no pending end request");
                errors++;
            end
            else
            begin
                g = goal_q.pop_front();
                if (goal_valid !== g.gv)
                begin
                    $error("goal_valid exp %0d got %0d", g.gv, goal_valid);
                    errors++;
                end
                if (goal_x !== g.gx)
                begin
                    $error("goal_x exp %0d got %0d", g.gx, goal_x);
                    errors++;
                end
                if (goal_y !== g.gy)
                begin
                    $error("goal_y exp %0d got %0d", g.gy, goal_y);
                    errors++;
                end
                if (box_count !== g.cnt)
                begin
                    $error("box_count exp %0d got %0d", g.cnt, box_count);
                    errors++;
                end
                if (table_overflow !== g.ovf)
                begin
                    $error("table_overflow exp %0d got %0d", g.ovf, table_overflow);
                    errors++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random stall bursts, or a long hold when stall_left is
    // loaded by a test.
    // ------------------------------------------------------------------
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else if (idle_en && $urandom_range(0, 5) == 0)
            begin
                out_ready  <= 1'b0;
                stall_left = $urandom_range(0, 7);
            end
            else
                out_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Sender. Called right after an edge; valid stays high from one request
    // to the next unless an idle burst is drawn.
    // ------------------------------------------------------------------
    task automatic send_request(input logic [1:0] k, input longint x,
                                input longint y, input longint w, input longint h);
        int gap;
        @(negedge clk);
        if (idle_en && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 8);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        kind     <= k;
        pos_x    <= x[cvgs_pkg::COORD_W-1:0];
        pos_y    <= y[cvgs_pkg::COORD_W-1:0];
        size_w   <= w[cvgs_pkg::SIZE_W-1:0];
        size_h   <= h[cvgs_pkg::SIZE_W-1:0];
        do @(posedge clk); while (!in_ready);
        track_request(k, x, y, w, h);
    endtask

    task automatic release_input();
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    // Waits until every goal has come back and the block has had time to
    // finish any box request, which produces no result.
    task automatic wait_idle();
        release_input();
        while (goal_q.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input int unsigned val);
        @(negedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        case (idx)
            cvgs_pkg::REG_VISIT_OFFSET: offset_mm = val & 16'hFFFF;
            cvgs_pkg::REG_REACH_RADIUS: reach_mm  = val & 16'hFFFF;
            cvgs_pkg::REG_DEDUP_RADIUS: dedup_mm  = val & 16'hFFFF;
            default:                    goal_mm   = val & 16'hFFFF;
        endcase
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic write_all(input int unsigned off, input int unsigned rch,
                             input int unsigned ddp, input int unsigned gl);
        write_reg(cvgs_pkg::REG_VISIT_OFFSET, off);
        write_reg(cvgs_pkg::REG_REACH_RADIUS, rch);
        write_reg(cvgs_pkg::REG_DEDUP_RADIUS, ddp);
        write_reg(cvgs_pkg::REG_GOAL_RADIUS, gl);
    endtask

    // ------------------------------------------------------------------
    // Random content. Positions mostly cluster around stored boxes so that
    // dedup, reach marking and goal selection all get exercised.
    // ------------------------------------------------------------------
    function automatic longint full_coord();
        return longint'(signed'(24'($urandom)));
    endfunction

    function automatic void pick_spot(output longint x, output longint y);
        int b, s;
        if (n_boxes == 0 || $urandom_range(0, 4) == 0)
        begin
            if ($urandom_range(0, 1))
            begin
                x = full_coord();
                y = full_coord();
            end
            else
            begin
                x = $urandom_range(0, 40000) - 20000;
                y = $urandom_range(0, 40000) - 20000;
            end
        end
        else
        begin
            b = $urandom_range(0, n_boxes - 1);
            s = $urandom_range(0, 4);
            if (s == 4)
            begin
                x = tbl_cx[b];
                y = tbl_cy[b];
            end
            else
                side_point(b, s, x, y);
            x = clamp_coord(x + $urandom_range(0, 1200) - 600);
            y = clamp_coord(y + $urandom_range(0, 1200) - 600);
        end
    endfunction

    task automatic send_random();
        longint x, y, w, h;
        int     r;
        r = $urandom_range(0, 99);
        pick_spot(x, y);
        if ($urandom_range(0, 7) == 0)
        begin
            w = $urandom_range(0, 20'hFFFFF);
            h = $urandom_range(0, 20'hFFFFF);
        end
        else
        begin
            w = $urandom_range(0, 3000);
            h = $urandom_range(0, 3000);
        end
        if (r < 45)
            send_request(cvgs_pkg::KIND_ODOM, x, y, w, h);
        else if (r < 57)
            send_request(cvgs_pkg::KIND_BOX, x, y, w, h);
        else if (r < 97)
            send_request(cvgs_pkg::KIND_END, x, y, w, h);
        else
            send_request(2'd3, x, y, w, h);
    endtask

    // ------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------
    task automatic test_directed();
        // Empty table: no unvisited point.
        send_request(cvgs_pkg::KIND_END, 0, 0, 0, 0);
        // Symmetric square box around the robot: four equal distances, and
        // the bottom point has to win the tie.
        send_request(cvgs_pkg::KIND_BOX, 0, 0, 1000, 1000);
        send_request(cvgs_pkg::KIND_END, 0, 0, 0, 0);
        // Same center and a center 299 away are dropped; exactly 300 is kept.
        send_request(cvgs_pkg::KIND_BOX, 0, 0, 5, 5);
        send_request(cvgs_pkg::KIND_BOX, 299, 0, 5, 5);
        send_request(cvgs_pkg::KIND_BOX, 0, 300, 7, 401);
        // Zero-width box and odd sizes.
        send_request(cvgs_pkg::KIND_BOX, 50000, -50000, 0, 0);
        send_request(cvgs_pkg::KIND_BOX, -50000, 50000, 1, 3);
        // Corner boxes with the largest sizes saturate their side points.
        send_request(cvgs_pkg::KIND_BOX, COORD_MAX, COORD_MIN, 20'hFFFFF, 20'hFFFFF);
        send_request(cvgs_pkg::KIND_BOX, COORD_MIN, COORD_MAX, 20'hFFFFF, 20'hFFFFF);
        // Robot right on a side point: within the goal radius, and the box
        // gets marked visited.
        send_request(cvgs_pkg::KIND_ODOM, 0, -1250, 0, 0);
        send_request(cvgs_pkg::KIND_END, 0, 0, 0, 0);
        send_request(cvgs_pkg::KIND_END, 0, 0, 0, 0);
        // Unused kind is ignored.
        send_request(2'd3, 123, 456, 1, 1);
        send_request(cvgs_pkg::KIND_ODOM, COORD_MAX, COORD_MAX, 0, 0);
        send_request(cvgs_pkg::KIND_END, 0, 0, 0, 0);
        send_request(cvgs_pkg::KIND_ODOM, COORD_MIN, COORD_MIN, 0, 0);
        send_request(cvgs_pkg::KIND_END, 0, 0, 0, 0);
        send_request(cvgs_pkg::KIND_ODOM, 50000, -50750, 0, 0);
        send_request(cvgs_pkg::KIND_END, 0, 0, 0, 0);
    endtask

    // Register settings, extremes included; a few random requests each.
    task automatic test_settings();
        int unsigned s[5][4] = '{'{0, 0, 0, 0},
                                 '{65535, 65535, 65535, 65535},
                                 '{0, 65535, 0, 65535},
                                 '{65535, 0, 65535, 0},
                                 '{750, 500, 300, 300}};
        for (int i = 0; i < 5; i++)
        begin
            wait_idle();
            write_all(s[i][0], s[i][1], s[i][2], s[i][3]);
            repeat (40) send_random();
        end
        for (int i = 0; i < 3; i++)
        begin
            wait_idle();
            write_all($urandom_range(0, 3000), $urandom_range(0, 3000),
                      $urandom_range(0, 1500), $urandom_range(0, 3000));
            repeat (40) send_random();
        end
    endtask

    // Receiver holds off while end requests keep coming, so the block backs
    // up and drops in_ready.
    task automatic test_backpressure();
        wait_idle();
        stall_left = 3000;
        repeat (6)
        begin
            send_request(cvgs_pkg::KIND_END, 0, 0, 0, 0);
            send_random();
        end
    endtask

    // Fills the table and pushes past it; dedup 0 keeps every new center.
    task automatic test_full_table();
        wait_idle();
        write_all(750, 500, 0, 300);
        while (n_boxes < cvgs_pkg::MAX_BOXES)
            send_request(cvgs_pkg::KIND_BOX, full_coord(), full_coord(),
                         $urandom_range(0, 4000), $urandom_range(0, 4000));
        send_request(cvgs_pkg::KIND_BOX, 1, 2, 3, 4);
        send_request(cvgs_pkg::KIND_END, 0, 0, 0, 0);
        send_request(cvgs_pkg::KIND_END, 0, 0, 0, 0);
        wait_idle();
        write_all(750, 500, 300, 300);
    endtask

    task automatic test_random(input int count, input bit with_idle);
        idle_en = with_idle;
        repeat (count) send_random();
    endtask

    initial
    begin
        errors      = 0;
        cycles      = 0;
        stall_left  = 0;
        idle_en     = 1'b1;
        robot_x     = 0;
        robot_y     = 0;
        n_boxes     = 0;
        dropped_box = 1'b0;
        offset_mm   = 750;
        reach_mm    = 500;
        dedup_mm    = 300;
        goal_mm     = 300;
        rst_n       = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        in_valid    = 1'b0;
        kind        = cvgs_pkg::KIND_ODOM;
        pos_x       = '0;
        pos_y       = '0;
        size_w      = '0;
        size_h      = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_settings();
        test_random(700, 1'b1);
        test_backpressure();
        test_full_table();
        test_random(250, 1'b1);
        test_random(200, 1'b0);

        release_input();
        while (goal_q.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        if (errors == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
